@@ hdl/iirdf2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared widths, codes, command types and rounding helpers for the
// direct form II IIR filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

	localparam int ORDER     = 3;
	localparam int FRAC_BITS = 20;
	localparam int COEF_W    = 24;
	localparam int SAMPLE_W  = 18;
	localparam int AUX_W     = 32;
	localparam int PROD_W    = COEF_W + AUX_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int RND_W     = ACC_W - FRAC_BITS;
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = 3;
	localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [AUX_W-1:0]    aux_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [RND_W-1:0]    rnd_t;

	typedef coef_t coef_bank_t [NUM_REGS];

	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_B3 = 3'd3,
		REG_A1 = 3'd4,
		REG_A2 = 3'd5,
		REG_A3 = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		VAL_W1   = 2'd0,
		VAL_W2   = 2'd1,
		VAL_W3   = 2'd2,
		VAL_WNEW = 2'd3
	} val_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD      = 2'd0,
		ACC_LOAD_X    = 2'd1,
		ACC_ADD       = 2'd2,
		ACC_LOAD_PROD = 2'd3
	} acc_op_t;

	typedef struct packed {
		acc_op_t  acc_op;
		reg_idx_t coef_sel;
		val_sel_t val_sel;
		logic     w_load;
		logic     y_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	localparam acc_t  ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
	localparam coef_t COEF_ONE   = coef_t'(1) <<< FRAC_BITS;

	function automatic rnd_t round_shift(input acc_t a);
		acc_t t;
		t = a + ROUND_HALF;
		return rnd_t'(t[ACC_W-1:FRAC_BITS]);
	endfunction

	function automatic aux_t round_sat_w(input acc_t a);
		rnd_t r;
		r = round_shift(a);
		if ((&r[RND_W-1:AUX_W-1]) || !(|r[RND_W-1:AUX_W-1]))
			return r[AUX_W-1:0];
		else if (r[RND_W-1])
			return {1'b1, {(AUX_W-1){1'b0}}};
		else
			return {1'b0, {(AUX_W-1){1'b1}}};
	endfunction

	function automatic sample_t round_sat_y(input acc_t a);
		rnd_t r;
		r = round_shift(a);
		if ((&r[RND_W-1:SAMPLE_W-1]) || !(|r[RND_W-1:SAMPLE_W-1]))
			return r[SAMPLE_W-1:0];
		else if (r[RND_W-1])
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

endpackage

@@ hdl/iirdf2_coef_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_coef_regs
// Coefficient register bank written through the configuration channel.
// ----------------------------------------------------------------------------
module iirdf2_coef_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iirdf2_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [iirdf2_pkg::COEF_W-1:0]    cfg_data,
	output iirdf2_pkg::coef_bank_t          coefs
);
	import iirdf2_pkg::*;

	coef_t coef_q [NUM_REGS];
	logic  wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && (cfg_index < REG_IDX_W'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coef_q[i] <= (i == int'(REG_B0)) ? COEF_ONE : '0;
		end else if (wr_en) begin
			coef_q[cfg_index] <= coef_t'(cfg_data);
		end
	end

	// taps beyond the filter order read as zero
	for (genvar i = 0; i < NUM_REGS; i++) begin : g_tap
		localparam int TAP = (i < 4) ? i : i - 3;
		if (TAP <= ORDER) begin : g_used
			assign coefs[i] = coef_q[i];
		end else begin : g_unused
			assign coefs[i] = '0;
		end
	end

endmodule

@@ hdl/iirdf2_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_ctrl
// Sequencer that issues the multiply-accumulate steps for one sample.
// ----------------------------------------------------------------------------
module iirdf2_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  iirdf2_pkg::dp_status_t status,
	output iirdf2_pkg::dp_cmd_t    cmd
);
	import iirdf2_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_A2   = 9'b000000010,
		S_A3   = 9'b000000100,
		S_AF   = 9'b000001000,
		S_W    = 9'b000010000,
		S_B2   = 9'b000100000,
		S_B3   = 9'b001000000,
		S_B0   = 9'b010000000,
		S_Y    = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.acc_op   = ACC_HOLD;
		cmd.coef_sel = REG_A1;
		cmd.val_sel  = VAL_W1;
		cmd.w_load   = 1'b0;
		cmd.y_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.acc_op = ACC_LOAD_X;
					state_d    = S_A2;
				end
			end
			S_A2: begin
				cmd.acc_op   = ACC_ADD;
				cmd.coef_sel = REG_A2;
				cmd.val_sel  = VAL_W2;
				state_d      = S_A3;
			end
			S_A3: begin
				cmd.acc_op   = ACC_ADD;
				cmd.coef_sel = REG_A3;
				cmd.val_sel  = VAL_W3;
				state_d      = S_AF;
			end
			S_AF: begin
				cmd.acc_op   = ACC_ADD;
				cmd.coef_sel = REG_B1;
				cmd.val_sel  = VAL_W1;
				state_d      = S_W;
			end
			S_W: begin
				cmd.acc_op   = ACC_LOAD_PROD;
				cmd.w_load   = 1'b1;
				cmd.coef_sel = REG_B2;
				cmd.val_sel  = VAL_W2;
				state_d      = S_B2;
			end
			S_B2: begin
				cmd.acc_op   = ACC_ADD;
				cmd.coef_sel = REG_B3;
				cmd.val_sel  = VAL_W3;
				state_d      = S_B3;
			end
			S_B3: begin
				cmd.acc_op   = ACC_ADD;
				cmd.coef_sel = REG_B0;
				cmd.val_sel  = VAL_WNEW;
				state_d      = S_B0;
			end
			S_B0: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_Y;
			end
			S_Y: begin
				if (status.out_free) begin
					cmd.y_load = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_A2)
		else $error("accepted sample did not start the sequence");

	a_result_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_load |-> status.out_free && state_q == S_Y)
		else $error("result pushed while output register is occupied");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input ready while a sample is in progress");

endmodule

@@ hdl/iirdf2_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_dp
// Shared multiplier, accumulator, delay line and output register.
// ----------------------------------------------------------------------------
module iirdf2_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iirdf2_pkg::dp_cmd_t    cmd,
	output iirdf2_pkg::dp_status_t status,
	input  iirdf2_pkg::sample_t    sample_in,
	input  iirdf2_pkg::coef_bank_t coefs,
	input  logic                   out_ready,
	output logic                   out_valid,
	output iirdf2_pkg::sample_t    sample_out
);
	import iirdf2_pkg::*;

	aux_t    w1_q, w2_q, w3_q;
	aux_t    wnew_q;
	prod_t   prod_s1;
	acc_t    acc_q;
	sample_t y_q;
	logic    out_valid_q;
	coef_t   coef_m;
	aux_t    val_m;

	always_comb begin
		case (cmd.coef_sel)
			REG_B0:  coef_m = coefs[0];
			REG_B1:  coef_m = coefs[1];
			REG_B2:  coef_m = coefs[2];
			REG_B3:  coef_m = coefs[3];
			REG_A1:  coef_m = coefs[4];
			REG_A2:  coef_m = coefs[5];
			REG_A3:  coef_m = coefs[6];
			default: coef_m = '0;
		endcase
	end

	always_comb begin
		case (cmd.val_sel)
			VAL_W1:   val_m = w1_q;
			VAL_W2:   val_m = w2_q;
			VAL_W3:   val_m = w3_q;
			VAL_WNEW: val_m = wnew_q;
			default:  val_m = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_t'(coef_m) * prod_t'(val_m);
	end

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD_X:    acc_q <= acc_t'(sample_in) <<< FRAC_BITS;
			ACC_ADD:       acc_q <= acc_q + acc_t'(prod_s1);
			ACC_LOAD_PROD: acc_q <= acc_t'(prod_s1);
			default:       acc_q <= acc_q;
		endcase
		if (cmd.w_load)
			wnew_q <= round_sat_w(acc_q);
		if (cmd.y_load)
			y_q <= round_sat_y(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= '0;
			w2_q <= '0;
			w3_q <= '0;
		end else if (cmd.y_load) begin
			w3_q <= w2_q;
			w2_q <= w1_q;
			w1_q <= wnew_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.y_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = y_q;

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.y_load))
		else $error("output valid rose without a result push");

	a_delay_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_load |=> w1_q == $past(wnew_q) && w2_q == $past(w1_q))
		else $error("delay line did not shift on result push");

	a_line_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.y_load |=> $stable(w1_q) && $stable(w3_q))
		else $error("delay line changed outside a result push");

endmodule

@@ hdl/iir_direct_form_two_filter_top.sv @@
`timescale 1ns / 1ps
// An accepted input steps through states A2, A3, AF, W, B2, B3, B0 and Y, where
//   it waits for a free output register; the single shared 24x32 multiplier and
//   accumulator handle the seven coefficient products of a sample in sequence.
// Only an idle sequencer takes a sample; writing the output register frees it.
// Reset (arst_n low, asynchronous): delay line cleared, b0 = 1.0, other
//   coefficients zero, no output pending.
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter_top
// Third-order direct form II IIR filter with Q3.20 coefficients.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [iirdf2_pkg::TDATA_W-1:0]   s_axis_tdata,  // [17:0] sample_in
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [iirdf2_pkg::TDATA_W-1:0]   m_axis_tdata,  // [17:0] sample_out
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iirdf2_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [iirdf2_pkg::COEF_W-1:0]    cfg_data
);
	import iirdf2_pkg::*;

	coef_bank_t coefs;
	dp_cmd_t    cmd;
	dp_status_t status;
	sample_t    sample_out;

	iirdf2_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	iirdf2_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	iirdf2_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample_in  (sample_t'(s_axis_tdata[SAMPLE_W-1:0])),
		.coefs      (coefs),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.sample_out (sample_out)
	);

	assign m_axis_tdata = {{(TDATA_W-SAMPLE_W){1'b0}}, sample_out};

endmodule
